// ----- design/flux_stream_encoder_top_macros.svh -----
// Assertion macros used by the flux stream encoder checker.
`ifndef FLUX_STREAM_ENCODER_TOP_MACROS_SVH
`define FLUX_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication under the synchronous reset.
`define FSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the synchronous reset.
`define FSE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fse_pkg.sv -----
// Shared constants, types and codes of the flux stream encoder.
`default_nettype none
package fse_pkg;

  localparam int unsigned MasterClkHz = ((18432000 * 73) / 14) / 2;
  localparam int unsigned SampleClkHz = MasterClkHz / 2;
  localparam int SampleW = $clog2(SampleClkHz + 1);
  localparam int ProdW = SampleW + 32;
  localparam int DivndW = ProdW + 1;
  localparam int DivCntW = $clog2(DivndW);

  localparam int MaxOverflowMarks = 31;
  localparam int SatLimit = MaxOverflowMarks * 65536 + 65535;
  localparam int ValW = $clog2(SatLimit + 1);
  localparam int MarkW = ValW - 16;

  localparam logic [31:0] TrackClkReset = 32'd24027428;

  // Command codes.
  localparam logic [1:0] FuncPulse = 2'd0;
  localparam logic [1:0] FuncStart = 2'd1;
  localparam logic [1:0] FuncEnd   = 2'd2;

  // Stream bytes.
  localparam logic [7:0] RecMark   = 8'h0D;
  localparam logic [7:0] RecStart  = 8'h01;
  localparam logic [7:0] RecIndex  = 8'h02;
  localparam logic [7:0] RecEnd    = 8'h03;
  localparam logic [7:0] HdrSize8  = 8'h08;
  localparam logic [7:0] HdrSize12 = 8'h0C;
  localparam logic [7:0] OvfMark   = 8'h0B;
  localparam logic [7:0] LongMark  = 8'h0C;
  localparam logic [15:0] ShortMax = 16'h000D;
  localparam logic [15:0] ByteMax  = 16'h00FF;
  localparam logic [15:0] MedMax   = 16'h07FF;

  // Record lengths in bytes.
  localparam logic [4:0] RecNStart = 5'd12;
  localparam logic [4:0] RecNIndex = 5'd16;
  localparam logic [4:0] RecNEnd   = 5'd20;

  typedef struct packed {
    logic              start;
    logic [DivndW-1:0] dividend;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DivndW-1:0] quotient;
    logic [31:0]       remainder;
  } div_rsp_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

endpackage
`default_nettype wire

// ----- design/fse_ifs.sv -----
// Valid/ready channel interfaces for commands and stream bytes.
`default_nettype none
interface fse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] pulse_len;
  logic [31:0] index_offset;

  modport source (output valid, output func, output pulse_len, output index_offset,
                  input ready);
  modport sink (input valid, input func, input pulse_len, input index_offset,
                output ready);
endinterface

interface fse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ----- design/fse_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fse_div
  import fse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [DivCntW-1:0] cnt;
  logic [DivndW-1:0]  acc;
  logic [31:0]        part;
  logic [31:0]        dvs;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic               ge;

  assign trial = {part, acc[DivndW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(DivndW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= req.dividend;
      part <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      part <= ge ? diff[31:0] : trial[31:0];
      acc  <= {acc[DivndW-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = acc;
  assign rsp.remainder = part;

endmodule
`default_nettype wire

// ----- design/fse_seq.sv -----
// Command sequencer: rescaling steps, record and pulse byte generation.
`default_nettype none
module fse_seq
  import fse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  func,
  input  logic [31:0] pulse_len,
  input  logic [31:0] index_offset,
  output logic        in_ready,
  input  logic [31:0] divisor,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  input  logic        out_free,
  output emit_t       emit
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_ADD  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_REC  = 8'b0001_0000,
    S_SAT  = 8'b0010_0000,
    S_MARK = 8'b0100_0000,
    S_CODE = 8'b1000_0000
  } state_t;

  state_t            state;
  logic              pul_ph;
  logic [4:0]        bidx;
  logic [MarkW-1:0]  marks;
  logic [31:0]       pos;
  logic [31:0]       elapsed;
  logic [31:0]       rem;

  logic [31:0]       len_r;
  logic [31:0]       ofs_r;
  logic [ProdW-1:0]  prod;
  logic [ValW-1:0]   v;
  logic [7:0]        rec_type;
  logic [7:0]        rec_size;
  logic [95:0]       rec_words;
  logic [4:0]        rec_n;
  logic              rec_fin;
  logic [2:0][7:0]   code;
  logic [1:0]        code_n;

  logic [7:0]        rec_byte;
  logic [3:0]        widx;
  logic [31:0]       opnd;
  logic [31:0]       sofs;
  logic [15:0]       rest;
  logic              fire;

  assign in_ready = (state == S_IDLE);
  assign opnd     = pul_ph ? len_r : ofs_r;
  assign sofs     = div_rsp.quotient[31:0];
  assign rest     = v[15:0];
  assign fire     = emit.valid && out_free;
  assign widx     = 4'(bidx - 5'd4);

  always_comb begin
    if (bidx < 5'd4) begin
      case (bidx[1:0])
        2'd0:    rec_byte = RecMark;
        2'd1:    rec_byte = rec_type;
        2'd2:    rec_byte = rec_size;
        default: rec_byte = 8'h00;
      endcase
    end else if (bidx < 5'd16) begin
      rec_byte = rec_words[{widx, 3'b000} +: 8];
    end else begin
      rec_byte = RecMark;
    end
  end

  always_comb begin
    div_req.start    = (state == S_ADD);
    div_req.dividend = DivndW'(prod) + DivndW'(pul_ph ? rem : 32'd0);
    div_req.divisor  = divisor;
  end

  always_comb begin
    emit = '0;
    case (state)
      S_REC: begin
        emit.valid = 1'b1;
        emit.data  = rec_byte;
        emit.last  = rec_fin && (bidx == rec_n - 5'd1);
      end
      S_MARK: begin
        emit.valid = 1'b1;
        emit.data  = OvfMark;
      end
      S_CODE: begin
        emit.valid = 1'b1;
        emit.data  = code[bidx[1:0]];
        emit.last  = (bidx[1:0] == code_n - 2'd1);
      end
      default: emit = '0;
    endcase
  end

  // Control and tracked stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pul_ph  <= 1'b0;
      bidx    <= '0;
      marks   <= '0;
      pos     <= '0;
      elapsed <= '0;
      rem     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          bidx <= '0;
          if (in_valid) begin
            case (func)
              FuncStart: begin
                pos     <= '0;
                elapsed <= '0;
                rem     <= '0;
                state   <= S_REC;
              end
              FuncEnd: begin
                state <= S_REC;
              end
              FuncPulse: begin
                pul_ph <= !((pulse_len == '0) || (index_offset < pulse_len));
                state  <= S_MUL;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: state <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            bidx <= '0;
            if (pul_ph) begin
              rem   <= div_rsp.remainder;
              state <= S_SAT;
            end else begin
              state <= S_REC;
            end
          end
        end
        S_REC: begin
          if (fire) begin
            if (bidx == rec_n - 5'd1) begin
              bidx <= '0;
              if (rec_fin) begin
                state <= S_IDLE;
              end else begin
                pul_ph <= 1'b1;
                state  <= S_MUL;
              end
            end else begin
              bidx <= bidx + 5'd1;
            end
          end
        end
        S_SAT: begin
          elapsed <= elapsed + 32'(v);
          marks   <= v[ValW-1:16];
          bidx    <= '0;
          state   <= (v[ValW-1:16] != '0) ? S_MARK : S_CODE;
        end
        S_MARK: begin
          if (fire) begin
            pos   <= pos + 32'd1;
            marks <= marks - 1'b1;
            if (marks == MarkW'(1)) begin
              state <= S_CODE;
            end
          end
        end
        S_CODE: begin
          if (fire) begin
            pos <= pos + 32'd1;
            if (bidx[1:0] == code_n - 2'd1) begin
              bidx  <= '0;
              state <= S_IDLE;
            end else begin
              bidx <= bidx + 5'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operands, record contents and cell code bytes.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      len_r <= pulse_len;
      ofs_r <= index_offset;
      if (func == FuncStart) begin
        rec_type  <= RecStart;
        rec_size  <= HdrSize8;
        rec_words <= '0;
        rec_n     <= RecNStart;
        rec_fin   <= 1'b1;
      end else begin
        // The first four of the end record's trailing filler bytes fill the third word slot.
        rec_type  <= RecEnd;
        rec_size  <= HdrSize8;
        rec_words <= {{4{RecMark}}, 32'd0, pos};
        rec_n     <= RecNEnd;
        rec_fin   <= 1'b1;
      end
    end
    if (state == S_MUL) begin
      prod <= ProdW'(SampleClkHz) * ProdW'(opnd);
    end
    if (state == S_DIV && div_rsp.done) begin
      if (pul_ph) begin
        v <= (div_rsp.quotient > DivndW'(SatLimit)) ? ValW'(SatLimit)
                                                     : div_rsp.quotient[ValW-1:0];
      end else begin
        rec_type  <= RecIndex;
        rec_size  <= HdrSize12;
        rec_words <= {elapsed + sofs, sofs, pos};
        rec_n     <= RecNIndex;
        rec_fin   <= (len_r == '0);
      end
    end
    if (state == S_SAT) begin
      code[2] <= rest[7:0];
      if (rest <= ShortMax) begin
        code[0] <= 8'h00;
        code[1] <= rest[7:0];
        code_n  <= 2'd2;
      end else if (rest <= ByteMax) begin
        code[0] <= rest[7:0];
        code[1] <= rest[7:0];
        code_n  <= 2'd1;
      end else if (rest <= MedMax) begin
        code[0] <= rest[15:8];
        code[1] <= rest[7:0];
        code_n  <= 2'd2;
      end else begin
        code[0] <= LongMark;
        code[1] <= rest[15:8];
        code_n  <= 2'd3;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/flux_stream_encoder_top.sv -----
// Top level of the flux stream encoder: config register, output stage, core.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    func, pulse_len, index_offset
//   out_ch    out  valid/ready    out_byte, last
//   cfg       in   cfg_we         cfg_wdata (track clock in Hz)
//
// A start or end request emits 12 or 20 bytes, one byte per cycle while out_ch
// does not stall. A pulse request is first rescaled by the 58-step serial
// divider, then emits one byte per cycle while out_ch does not stall;
// a pulse that also carries an index mark runs the divider twice.
// Reset (rst, synchronous) clears the stream position, elapsed clock and
// remainder and loads the track clock with its default.
// A stall on out_ch holds the sequencer; the final byte of a request sits in
// the output register while the next request is already taken.
`default_nettype none
module flux_stream_encoder_top
  import fse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  fse_in_if.sink      in_ch,
  fse_out_if.source   out_ch
);

  logic [31:0] track_clk;
  logic [31:0] divisor;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  emit_t       emit;
  logic        out_free;
  logic        out_vld;
  logic [7:0]  out_data;
  logic        out_last;

  // Track clock register; a zero rate is handled as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      track_clk <= TrackClkReset;
    end else if (cfg_we) begin
      track_clk <= cfg_wdata;
    end
  end

  assign divisor = (track_clk == '0) ? 32'd1 : track_clk;

  fse_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .func         (in_ch.func),
    .pulse_len    (in_ch.pulse_len),
    .index_offset (in_ch.index_offset),
    .in_ready     (in_ch.ready),
    .divisor      (divisor),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_free     (out_free),
    .emit         (emit)
  );

  fse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register: the sequencer only moves on to its next byte when this stage can load.
  assign out_free = !out_vld || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_free) begin
      out_vld <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      out_data <= emit.data;
      out_last <= emit.last;
    end
  end

  assign out_ch.valid    = out_vld;
  assign out_ch.out_byte = out_data;
  assign out_ch.last     = out_last;

endmodule
`default_nettype wire

// ----- design/fse_chk.sv -----
// Port-level checker for the flux stream encoder and its bind.
`default_nettype none
`include "flux_stream_encoder_top_macros.svh"
module fse_chk
  import fse_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic in_acc;
  logic busy_cmd;

  assign in_acc   = in_valid && in_ready;
  assign busy_cmd = (func == FuncPulse) || (func == FuncStart) || (func == FuncEnd);

  `FSE_ASSERT_NXT(a_busy_after_cmd, clk, rst, in_acc && busy_cmd, !in_ready, "ready after command")
  `FSE_ASSERT_NXT(a_unknown_ignored, clk, rst, in_acc && !busy_cmd, in_ready, "unknown not ignored")
  `FSE_ASSERT_IMP(a_idle_tail_last, clk, rst, in_ready && out_valid, out_last, "idle, pending not last")
  `FSE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "output dropped")

endmodule

bind flux_stream_encoder_top fse_chk u_fse_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .func      (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last)
);
`default_nettype wire

// ----- sim/flux_stream_encoder_top_tb.sv -----
// Self-checking testbench for the flux stream encoder top level.
`timescale 1ns / 100ps
module flux_stream_encoder_top_tb;
  import fse_pkg::*;

  // Command code that the encoder drops without producing any byte.
  localparam logic [1:0] FuncUnused = 2'd3;

  // Byte that precedes a short cell value, and the pad byte of a record header.
  localparam logic [7:0] CellEscape = 8'h00;
  localparam logic [7:0] HdrPad = 8'h00;

  // Rescaling constants. One overflow mark stands for a full cell span.
  localparam longint unsigned SampleHz = SampleClkHz;
  localparam longint unsigned CellSpan = 65536;
  localparam longint unsigned CellLimit = MaxOverflowMarks * CellSpan + CellSpan - 1;

  // A pulse with an index mark runs the serial divider twice, before its index
  // record and again before its cell bytes, so the quiet stretch covers any
  // request that is still in flight, including one that never produces a byte.
  localparam int QuietCycles = 256;

  // Longest legal stretch without any handshake: sender gap, two divider runs,
  // receiver stall and the quiet pause before a register write, with margin.
  localparam int StallLimit = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  fse_in_if  cmd_if ();
  fse_out_if byte_if ();

  flux_stream_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (cmd_if),
    .out_ch    (byte_if)
  );

  // Shadow copy of the encoder state, advanced once per accepted request.
  logic [31:0] track_clk_hz;
  logic [31:0] stream_pos;
  logic [31:0] elapsed_clk;
  logic [31:0] scale_rem;

  // Bytes that the request being predicted produces, in stream order.
  logic [7:0]   request_bytes[$];
  // Bytes that the encoder still owes, oldest first.
  stream_byte_t expected_bytes[$];

  int mismatch_count;
  int stall_count;
  int sink_hold;
  bit src_calm;
  bit sink_calm;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Stream prediction
  // ---------------------------------------------------------------------------

  function automatic void put_stream_byte(input logic [7:0] value);
    request_bytes.push_back(value);
  endfunction

  // Words go out least significant byte first.
  function automatic void put_stream_word(input logic [31:0] w);
    put_stream_byte(w[7:0]);
    put_stream_byte(w[15:8]);
    put_stream_byte(w[23:16]);
    put_stream_byte(w[31:24]);
  endfunction

  function automatic void put_record_header(input logic [7:0] rec_kind,
                                            input logic [7:0] rec_len);
    put_stream_byte(RecMark);
    put_stream_byte(rec_kind);
    put_stream_byte(rec_len);
    put_stream_byte(HdrPad);
  endfunction

  // A zero track clock is taken as one so that the rescaling never divides by zero.
  function automatic longint unsigned track_divisor();
    return (track_clk_hz == 32'd0) ? 64'd1 : {32'd0, track_clk_hz};
  endfunction

  // Fills request_bytes with the stream bytes of one request and updates the
  // shadow state the way the encoder does.
  function automatic void encode_request(input logic [1:0] func, input logic [31:0] len,
                                         input logic [31:0] ofs);
    longint unsigned div;
    longint unsigned prod;
    longint unsigned quo;
    logic [31:0]     sofs;
    logic [15:0]     rest;
    request_bytes.delete();
    div = track_divisor();
    case (func)
      FuncStart: begin
        put_record_header(RecStart, HdrSize8);
        put_stream_word(32'd0);
        put_stream_word(32'd0);
        stream_pos = 32'd0;
        elapsed_clk = 32'd0;
        scale_rem = 32'd0;
      end
      FuncEnd: begin
        // The end record leaves the state alone.
        put_record_header(RecEnd, HdrSize8);
        put_stream_word(stream_pos);
        put_stream_word(32'd0);
        repeat (8) put_stream_byte(RecMark);
      end
      FuncPulse: begin
        // An index record comes first when the mark falls inside the pulse, or
        // when the pulse has no length at all. Its offset is rescaled on its own,
        // without the carried remainder, and only the low word is kept.
        if (len == 32'd0 || ofs < len) begin
          prod = SampleHz * ofs;
          quo = prod / div;
          sofs = quo[31:0];
          put_record_header(RecIndex, HdrSize12);
          put_stream_word(stream_pos);
          put_stream_word(sofs);
          put_stream_word(elapsed_clk + sofs);
        end
        if (len != 32'd0) begin
          prod = SampleHz * len + scale_rem;
          quo = prod / div;
          scale_rem = prod % div;
          // Huge pulses saturate; the remainder is kept as computed.
          if (quo > CellLimit) quo = CellLimit;
          elapsed_clk = elapsed_clk + quo[31:0];
          while (quo >= CellSpan) begin
            put_stream_byte(OvfMark);
            stream_pos = stream_pos + 32'd1;
            quo = quo - CellSpan;
          end
          rest = quo[15:0];
          if (rest <= ShortMax) begin
            put_stream_byte(CellEscape);
            put_stream_byte(rest[7:0]);
            stream_pos = stream_pos + 32'd2;
          end else if (rest <= ByteMax) begin
            put_stream_byte(rest[7:0]);
            stream_pos = stream_pos + 32'd1;
          end else if (rest <= MedMax) begin
            put_stream_byte(rest[15:8]);
            put_stream_byte(rest[7:0]);
            stream_pos = stream_pos + 32'd2;
          end else begin
            put_stream_byte(LongMark);
            put_stream_byte(rest[15:8]);
            put_stream_byte(rest[7:0]);
            stream_pos = stream_pos + 32'd3;
          end
        end
      end
      default: begin
        // Unused command: nothing comes out and nothing changes.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  // Idle stretch in cycles: mostly none or short, now and then a long one.
  function automatic int idle_span(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pulse lengths are picked from a target cell value under the current track
  // clock, so that every cell coding shows up when the clock is at least the
  // sample clock. Some are zero (index only) and some are raw 32-bit noise.
  function automatic logic [31:0] pick_pulse_len();
    longint unsigned target;
    longint unsigned scaled;
    int              roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 32'd0;
    if (roll < 13) return $urandom;
    case ($urandom_range(0, 4))
      0: target = $urandom_range(0, 13);
      1: target = $urandom_range(14, 255);
      2: target = $urandom_range(256, 2047);
      3: target = $urandom_range(2048, 65535);
      default: target = $urandom_range(65536, CellLimit + 4 * CellSpan);
    endcase
    scaled = target * track_divisor() / SampleHz;
    if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
    if (scaled == 64'd0) scaled = 64'd1;
    return scaled[31:0];
  endfunction

  // Roughly one pulse in six carries an index mark inside it.
  function automatic logic [31:0] pick_index_offset(input logic [31:0] len);
    int roll;
    roll = $urandom_range(0, 99);
    if (len != 32'd0 && roll < 16) return $urandom % len;
    if (roll < 60) return len + $urandom_range(0, 1000);
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver, register writes and idle pauses
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the falling edge after it was taken, with
  // valid still high so that a following request can go out back to back.
  task automatic push_request(input logic [1:0] func, input logic [31:0] len,
                              input logic [31:0] ofs);
    int gap;
    gap = idle_span(src_calm);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.func <= func;
    cmd_if.pulse_len <= len;
    cmd_if.index_offset <= ofs;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    encode_request(func, len, ofs);
    foreach (request_bytes[i]) begin
      expected_bytes.push_back('{data: request_bytes[i],
                                 last: (i == request_bytes.size() - 1)});
    end
    @(negedge clk);
  endtask

  // Holds the sender until every owed byte has come out, then lets the encoder
  // run quiet long enough for a request that yields no byte to finish.
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic write_track_clock(input logic [31:0] hz);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we <= 1'b0;
    track_clk_hz = hz;
  endtask

  // Sends whole tracks (start, pulses, end) with random content until the
  // budget of counted requests is used. A few tracks lack their start or end,
  // and unused commands are sprinkled in as noise that does not count.
  task automatic run_tracks(input int budget);
    int          sent;
    int          pulses;
    logic [31:0] len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) != 0) begin
        push_request(FuncStart, $urandom, $urandom);
        sent++;
      end
      pulses = $urandom_range(2, 16);
      repeat (pulses) begin
        if ($urandom_range(0, 24) == 0) push_request(FuncUnused, $urandom, $urandom);
        len = pick_pulse_len();
        push_request(FuncPulse, len, pick_index_offset(len));
        sent++;
      end
      if ($urandom_range(0, 9) != 0) begin
        push_request(FuncEnd, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Under the reset track clock the sample clock equals the track clock, so a
  // pulse length maps straight onto its cell value. Walks every cell coding
  // boundary, the index-mark cases, saturation and the unused command.
  task automatic test_directed_codes();
    push_request(FuncStart, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(FuncPulse, 32'h0000_000D, 32'hFFFF_FFFF);
    push_request(FuncPulse, 32'd0, 32'd0);
    push_request(FuncPulse, 32'd1, 32'd0);
    push_request(FuncPulse, 32'h0000_000E, 32'h0000_000E);
    push_request(FuncPulse, 32'h0000_00FF, 32'h0000_00FE);
    push_request(FuncPulse, 32'h0000_0100, 32'hFFFF_FFFF);
    push_request(FuncPulse, 32'h0000_07FF, 32'h0000_0800);
    push_request(FuncPulse, 32'h0000_0800, 32'h0000_0001);
    push_request(FuncPulse, 32'h0000_FFFF, 32'h0001_0000);
    push_request(FuncPulse, 32'h0001_0000, 32'h0001_0000);
    push_request(FuncPulse, 32'h0001_000D, 32'h8000_0000);
    push_request(FuncPulse, CellLimit, 32'h7FFF_FFFF);
    push_request(FuncPulse, CellLimit + 1, 32'h0000_0000);
    // Largest request: an index record plus a saturated pulse.
    push_request(FuncPulse, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    push_request(FuncUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(FuncEnd, 32'h0000_0000, 32'h0000_0000);
    push_request(FuncStart, 32'h5555_5555, 32'hAAAA_AAAA);
    push_request(FuncPulse, 32'd0, 32'hFFFF_FFFF);
    push_request(FuncEnd, 32'hAAAA_AAAA, 32'h5555_5555);
    push_request(FuncEnd, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(FuncPulse, 32'h0000_1234, 32'h0000_1000);
  endtask

  // Random tracks at the reset clock, with the sender held once in the middle
  // until the whole stream so far has drained.
  task automatic test_reset_clock_tracks();
    run_tracks(60);
    settle();
    src_calm = 1'b1;
    run_tracks(60);
    src_calm = 1'b0;
  endtask

  // Track clock at its limits: one (every pulse saturates), zero (taken as
  // one) and the largest value (remainder grows).
  task automatic test_track_clock_extremes();
    write_track_clock(32'd1);
    run_tracks(30);
    write_track_clock(32'd0);
    run_tracks(20);
    write_track_clock(32'hFFFF_FFFF);
    run_tracks(50);
  endtask

  // Clocks that do not divide the sample clock, so the remainder carries.
  task automatic test_random_clocks();
    repeat (3) begin
      write_track_clock($urandom_range(1000000, 200000000));
      src_calm = ($urandom_range(0, 2) == 0);
      run_tracks(60);
    end
    src_calm = 1'b0;
  endtask

  task automatic test_restored_clock();
    write_track_clock(TrackClkReset);
    run_tracks(40);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls of random length, with calm stretches that come and go.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
    if (sink_hold > 0) begin
      byte_if.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      byte_if.ready <= 1'b1;
      sink_hold = idle_span(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Stream checker: each byte taken is matched against the oldest one owed.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_stream
    stream_byte_t want;
    if (!rst && byte_if.valid && byte_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected stream byte %02h last %0b", $time, byte_if.out_byte,
                 byte_if.last);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (byte_if.out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                   byte_if.out_byte);
          mismatch_count++;
        end
        if (byte_if.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b (byte %02h)", $time, want.last,
                   byte_if.last, want.data);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if no handshake happens on either channel for too long.
  initial begin : watchdog
    stall_count = 0;
    while (stall_count < StallLimit) begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (byte_if.valid && byte_if.ready))
        stall_count = 0;
      else
        stall_count++;
    end
    $display("flux_stream_encoder_top_tb NOT OK");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 32'd0;
    cmd_if.valid = 1'b0;
    cmd_if.func = FuncPulse;
    cmd_if.pulse_len = 32'd0;
    cmd_if.index_offset = 32'd0;
    byte_if.ready = 1'b0;
    track_clk_hz = TrackClkReset;
    stream_pos = 32'd0;
    elapsed_clk = 32'd0;
    scale_rem = 32'd0;
    mismatch_count = 0;
    sink_hold = 0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_directed_codes();
    test_reset_clock_tracks();
    test_track_clock_extremes();
    test_random_clocks();
    test_restored_clock();

    // Drain and give the encoder its tail time before judging.
    settle();
    if (mismatch_count == 0)
      $display("flux_stream_encoder_top_tb OK");
    else
      $display("flux_stream_encoder_top_tb NOT OK");
    $finish;
  end

endmodule
